@@ rtl/core/lobm_pkg.sv @@
// Package for the limit order book matcher: field widths, op codes, result records.
// No dependencies.
`timescale 1ns / 1ps
package lobm_pkg;
  localparam int unsigned MaxOrdersDefault = 64;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned PriceW = 17;
  localparam int unsigned SumW   = 22;
  localparam int unsigned IdW    = 7;
  localparam logic [PriceW-1:0] NoAsk = 17'd99999;

  typedef enum logic [1:0] {
    OP_BUY    = 2'd0,
    OP_SELL   = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]        op;
    logic [SizeW-1:0]  size;
    logic [PriceW-1:0] price;
    logic [IdW-1:0]    cid;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [SizeW-1:0]  fill_size;
    logic [PriceW-1:0] trade_price;
    logic [SumW-1:0]   bid_size;
    logic [PriceW-1:0] bid_px;
    logic [SumW-1:0]   ask_size;
    logic [PriceW-1:0] ask_px;
    logic              rejected;
    logic              last;
  } result_t;
endpackage

@@ rtl/core/lobm_front.sv @@
// Front part: accepts input items into a two-entry queue for the back part.
// Depends on lobm_pkg.
`timescale 1ns / 1ps
module lobm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lobm_pkg::item_t       item_i,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output lobm_pkg::item_t       q_item_o
);
  lobm_pkg::item_t buf_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= item_i;
  end
endmodule

@@ rtl/core/lobm_back.sv @@
// Back part: runs one item at a time over the slot store with a scanning sequencer,
// plus the generic registered-read RAM that holds the slots. Depends on lobm_pkg.
`timescale 1ns / 1ps
module lobm_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

module lobm_back #(
  parameter int unsigned MaxOrders = lobm_pkg::MaxOrdersDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  lobm_pkg::item_t  q_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lobm_pkg::result_t out_o
);
  localparam int unsigned SlotW = (MaxOrders > 1) ? $clog2(MaxOrders) : 1;
  localparam int unsigned CntW  = $clog2(MaxOrders + 1);
  localparam int unsigned IdW   = lobm_pkg::IdW;
  localparam logic [IdW-1:0]  MaxId   = IdW'(MaxOrders);
  localparam logic [CntW-1:0] ScanEnd = CntW'(MaxOrders);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FILL, S_REST, S_CANC, S_BEST, S_SUM, S_EMIT
  } state_e;

  typedef struct packed {
    logic                        buy;
    logic [lobm_pkg::PriceW-1:0] price;
    logic [lobm_pkg::SizeW-1:0]  rem;
  } slot_t;

  state_e state_q;
  logic [CntW-1:0]  next_q;
  logic [SlotW-1:0] me_q;
  lobm_pkg::item_t  cur_q;
  logic [CntW-1:0]  idx_q, rix_q;
  logic             rv_q;
  logic             found_q;
  slot_t            best_q;
  logic [SlotW-1:0] best_ix_q;
  logic             bfound_q, afound_q;
  logic [lobm_pkg::PriceW-1:0] bid_q, ask_q;
  logic [lobm_pkg::SumW-1:0]   bsum_q, asum_q;
  logic             rej_q;
  logic             ovalid_q;
  lobm_pkg::result_t out_q;

  slot_t            rd_word, wr_word;
  logic             we;
  logic [SlotW-1:0] waddr, raddr;
  logic [IdW-1:0]   cid_m1;
  logic             cid_ok, full, scan_end, out_free, emit;
  logic             is_buy, live, better, bid_better, ask_better, stop;
  logic [lobm_pkg::SizeW-1:0] take, left;
  logic [lobm_pkg::SumW-1:0]  rem_ext;

  lobm_ram #(.Width($bits(slot_t)), .Depth(MaxOrders), .AddrW(SlotW)) u_slots (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wr_word), .raddr_i(raddr),
    .rdata_o(rd_word)
  );

  assign full     = (next_q == ScanEnd);
  assign scan_end = (idx_q == ScanEnd);
  assign raddr    = scan_end ? '0 : idx_q[SlotW-1:0];
  assign out_free = !ovalid_q || !out_stall_i;
  assign is_buy   = (cur_q.op == lobm_pkg::OP_BUY);
  // slots at or past the fill count hold no live order and read as empty
  assign live     = rv_q && (rix_q < next_q) && (rd_word.rem != '0);
  // candidate resting order on the opposite side for matching
  assign better = live && (rd_word.buy != is_buy) &&
                  (!found_q || (is_buy ? rd_word.price < best_q.price
                                       : rd_word.price > best_q.price));
  assign bid_better = live && rd_word.buy && (!bfound_q || rd_word.price > bid_q);
  assign ask_better = live && !rd_word.buy && (!afound_q || rd_word.price < ask_q);
  assign stop   = !found_q || (is_buy ? best_q.price > cur_q.price
                                      : best_q.price < cur_q.price);
  assign take   = (cur_q.size < best_q.rem) ? cur_q.size : best_q.rem;
  assign left   = cur_q.size - take;
  assign rem_ext = {{(lobm_pkg::SumW - lobm_pkg::SizeW){1'b0}}, rd_word.rem};
  assign cid_m1 = cur_q.cid - IdW'(1);
  assign cid_ok = (cur_q.cid != '0) && (cur_q.cid <= MaxId);
  assign emit   = ((state_q == S_FILL) && !stop) || (state_q == S_EMIT);
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wr_word = '0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && !full) begin
          we            = 1'b1;
          waddr         = next_q[SlotW-1:0];
          wr_word.buy   = (q_item_i.op == lobm_pkg::OP_BUY);
          wr_word.price = q_item_i.price;
        end
      end
      S_FILL: begin
        if (!stop && out_free) begin
          we          = 1'b1;
          waddr       = best_ix_q;
          wr_word     = best_q;
          wr_word.rem = best_q.rem - take;
        end
      end
      S_REST: begin
        we            = 1'b1;
        waddr         = me_q;
        wr_word.buy   = is_buy;
        wr_word.price = cur_q.price;
        wr_word.rem   = cur_q.size;
      end
      S_CANC: begin
        if (cid_ok) begin
          we    = 1'b1;
          waddr = cid_m1[SlotW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      next_q    <= '0;
      me_q      <= '0;
      cur_q     <= '0;
      idx_q     <= '0;
      rix_q     <= '0;
      rv_q      <= 1'b0;
      found_q   <= 1'b0;
      best_q    <= '0;
      best_ix_q <= '0;
      bfound_q  <= 1'b0;
      afound_q  <= 1'b0;
      bid_q     <= '0;
      ask_q     <= lobm_pkg::NoAsk;
      bsum_q    <= '0;
      asum_q    <= '0;
      rej_q     <= 1'b0;
      ovalid_q  <= 1'b0;
      out_q     <= '0;
    end else begin
      if (out_free) ovalid_q <= emit;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cur_q <= q_item_i;
            if (full) begin
              rej_q   <= 1'b1;
              state_q <= S_BEST;
            end else begin
              rej_q  <= 1'b0;
              me_q   <= next_q[SlotW-1:0];
              next_q <= next_q + CntW'(1);
              case (q_item_i.op)
                lobm_pkg::OP_BUY, lobm_pkg::OP_SELL: begin
                  state_q <= (q_item_i.size == '0) ? S_REST : S_SCAN;
                end
                lobm_pkg::OP_CANCEL: state_q <= S_CANC;
                default: state_q <= S_BEST;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (!rv_q) found_q <= 1'b0;
          else if (better) begin
            best_q    <= rd_word;
            best_ix_q <= rix_q[SlotW-1:0];
            found_q   <= 1'b1;
          end
          if (scan_end) begin
            idx_q <= '0; rv_q <= 1'b0; state_q <= S_FILL;
          end else begin
            idx_q <= idx_q + CntW'(1); rv_q <= 1'b1; rix_q <= idx_q;
          end
        end
        S_FILL: begin
          if (stop) state_q <= S_REST;
          else if (out_free) begin
            out_q <= '{kind: 1'b0, fill_size: take, trade_price: best_q.price,
                       bid_size: '0, bid_px: '0, ask_size: '0, ask_px: '0,
                       rejected: 1'b0, last: 1'b0};
            cur_q.size <= left;
            state_q <= (left == '0) ? S_REST : S_SCAN;
          end
        end
        S_REST: state_q <= S_BEST;
        S_CANC: state_q <= S_BEST;
        S_BEST: begin
          if (!rv_q) begin
            bid_q <= '0; ask_q <= lobm_pkg::NoAsk;
            bfound_q <= 1'b0; afound_q <= 1'b0;
          end else begin
            if (bid_better) begin bid_q <= rd_word.price; bfound_q <= 1'b1; end
            if (ask_better) begin ask_q <= rd_word.price; afound_q <= 1'b1; end
          end
          if (scan_end) begin
            idx_q <= '0; rv_q <= 1'b0; state_q <= S_SUM;
          end else begin
            idx_q <= idx_q + CntW'(1); rv_q <= 1'b1; rix_q <= idx_q;
          end
        end
        S_SUM: begin
          if (!rv_q) begin
            bsum_q <= '0; asum_q <= '0;
          end else begin
            if (live && rd_word.buy && rd_word.price == bid_q) bsum_q <= bsum_q + rem_ext;
            if (live && !rd_word.buy && rd_word.price == ask_q) asum_q <= asum_q + rem_ext;
          end
          if (scan_end) begin
            idx_q <= '0; rv_q <= 1'b0; state_q <= S_EMIT;
          end else begin
            idx_q <= idx_q + CntW'(1); rv_q <= 1'b1; rix_q <= idx_q;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q <= '{kind: 1'b1, fill_size: '0, trade_price: '0,
                       bid_size: bsum_q, bid_px: bid_q, ask_size: asum_q,
                       ask_px: ask_q, rejected: rej_q, last: 1'b1};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/limit_order_book_matcher.sv @@
// Limit order book matcher, price-time priority over MaxOrders slots held in one RAM.
// Each item ends in one quote after a best-price scan and a size-sum scan over the slots;
// a buy or sell first runs one matching scan pass per fill, one more when size is left
// over; zero size, cancel, full store or unknown op skip it; output stalls hold the item.
// The back part takes one item at a time; the front queue holds two items.
// Reset: asynchronous, clears slot count and best prices; slots past the count read empty.
`timescale 1ns / 1ps
module limit_order_book_matcher #(
  parameter int unsigned MaxOrders = lobm_pkg::MaxOrdersDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] order_size_i,
  input  logic [16:0] order_price_i,
  input  logic [6:0]  cancel_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [15:0] fill_size_o,
  output logic [16:0] trade_price_o,
  output logic [21:0] bid_size_o,
  output logic [16:0] bid_px_o,
  output logic [21:0] ask_size_o,
  output logic [16:0] ask_px_o,
  output logic        rejected_o,
  output logic        last_o
);
  lobm_pkg::item_t   item, q_item;
  lobm_pkg::result_t res;
  logic q_valid, q_pop;

  assign item = '{op: op_i, size: order_size_i, price: order_price_i, cid: cancel_id_i};

  lobm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .item_i(item),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  lobm_back #(.MaxOrders(MaxOrders)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o, .out_stall_i, .out_o(res)
  );

  assign kind_o = res.kind;
  assign fill_size_o = res.fill_size;
  assign trade_price_o = res.trade_price;
  assign bid_size_o = res.bid_size;
  assign bid_px_o = res.bid_px;
  assign ask_size_o = res.ask_size;
  assign ask_px_o = res.ask_px;
  assign rejected_o = res.rejected;
  assign last_o = res.last;

  a_trade_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> !last_o && !rejected_o) else $error("trade flags");
  a_quote_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o) else $error("quote not last");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop of empty queue");
endmodule
